// ----- design/and_xor_cursor_compositor_macros.svh -----
// Assertion macros shared by the cursor compositor checkers.
// No dependencies; included by the checker file.
`ifndef AND_XOR_CURSOR_COMPOSITOR_MACROS_SVH
`define AND_XOR_CURSOR_COMPOSITOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AXCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("axcc assertion failed");

// Check a property on every clock edge, reset included.
`define AXCC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("axcc assertion failed");

`endif

// ----- design/axcc_pkg.sv -----
// Shared types and constants of the AND/XOR cursor compositor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package axcc_pkg;

   localparam int PIXEL_W     = 8;
   localparam int FRAME_REG_W = 13;
   localparam int WIN_W       = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [FRAME_REG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [FRAME_REG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_PLACE   = 3'd1,
      OP_COMPOSE = 3'd2,
      OP_RESTORE = 3'd3,
      OP_HIDE    = 3'd4
   } op_type;

   typedef struct packed {
      logic             shown;
      logic             hit;
      logic [WIN_W-1:0] left;
      logic [WIN_W-1:0] top;
      logic [WIN_W-1:0] right;
      logic [WIN_W-1:0] bottom;
   } win_info_type;

endpackage

// ----- design/axcc_mask_mem.sv -----
// AND and XOR mask rows in one synchronous memory, one row per entry.
// Per-row valid bits make unwritten rows read as zero. Uses axcc_pkg.
`timescale 1ns / 1ps
module axcc_mask_mem
   import axcc_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata_and,
   input  logic [31:0]   wdata_xor,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata_and,
   output logic [31:0]   rdata_xor
);

   logic [63:0]      mask_mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [63:0]      rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mask_mem_ff[waddr] <= {wdata_and, wdata_xor};
      end
      if (re) begin
         rd_data_ff <= mask_mem_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (re) begin
            rd_vld_ff <= valid_ff[raddr];
         end
      end
   end

   assign rdata_and = rd_vld_ff ? rd_data_ff[63:32] : 32'd0;
   assign rdata_xor = rd_vld_ff ? rd_data_ff[31:0] : 32'd0;

endmodule

// ----- design/axcc_bg_mem.sv -----
// Saved background pixels under the cursor, one byte per cursor cell.
// Synchronous memory with registered read. Uses axcc_pkg.
`timescale 1ns / 1ps
module axcc_bg_mem
   import axcc_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  logic [PIXEL_W-1:0] wdata,
   input  logic               re,
   input  logic [AW-1:0]      raddr,
   output logic [PIXEL_W-1:0] rdata
);

   logic [PIXEL_W-1:0] bg_mem_ff [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         bg_mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= bg_mem_ff[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// ----- design/axcc_window.sv -----
// Frame size registers, cursor placement, clipping and hit test.
// Uses axcc_pkg for op codes, register indexes and the window status struct.
`timescale 1ns / 1ps
module axcc_window
   import axcc_pkg::*;
#(
   parameter int CURSOR_DIM    = 32,
   parameter int FRAME_DIM_MAX = 4096,
   parameter int RW            = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_accept,
   input  op_type                 op,
   input  logic [15:0]            pos_x,
   input  logic [15:0]            pos_y,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FRAME_REG_W-1:0] csr_wdata,
   output win_info_type           win,
   output logic [RW-1:0]          row_off,
   output logic [RW-1:0]          col_off
);

   localparam int BW = $clog2(FRAME_DIM_MAX);
   localparam int DW = $clog2(FRAME_DIM_MAX + 1);
   localparam int EW = (DW > FRAME_REG_W) ? DW : FRAME_REG_W;
   localparam int CW = (EW > 17) ? EW : 17;
   localparam int OW = (BW > WIN_W) ? BW : WIN_W;

   logic [FRAME_REG_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic                   shown_ff, shown_in;
   logic [BW-1:0]          left_ff, left_in, top_ff, top_in;
   logic [BW-1:0]          right_ff, right_in, bottom_ff, bottom_in;

   logic [EW-1:0] w_eff, h_eff;
   logic [CW-1:0] x_c, y_c, w_c, h_c, r_c, b_c, r_clip, b_clip;
   logic [CW-1:0] left_c, top_c, right_c, bottom_c;
   logic [OW-1:0] left_o, top_o, right_o, bottom_o;

   always_comb begin
      w_eff = (EW'(fw_ff) > EW'(FRAME_DIM_MAX)) ? EW'(FRAME_DIM_MAX) : EW'(fw_ff);
      h_eff = (EW'(fh_ff) > EW'(FRAME_DIM_MAX)) ? EW'(FRAME_DIM_MAX) : EW'(fh_ff);
      x_c      = CW'(pos_x);
      y_c      = CW'(pos_y);
      w_c      = CW'(w_eff);
      h_c      = CW'(h_eff);
      r_c      = x_c + CW'(CURSOR_DIM - 1);
      b_c      = y_c + CW'(CURSOR_DIM - 1);
      r_clip   = (r_c >= w_c) ? (w_c - CW'(1)) : r_c;
      b_clip   = (b_c >= h_c) ? (h_c - CW'(1)) : b_c;
      left_c   = CW'(left_ff);
      top_c    = CW'(top_ff);
      right_c  = CW'(right_ff);
      bottom_c = CW'(bottom_ff);
   end

   always_comb begin
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      shown_in  = shown_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (item_accept) begin
         case (op)
            OP_PLACE: begin
               if (w_c != '0 && h_c != '0) begin
                  shown_in = 1'b0;
                  if (x_c < w_c && y_c < h_c) begin
                     left_in   = BW'(x_c);
                     top_in    = BW'(y_c);
                     right_in  = BW'(r_clip);
                     bottom_in = BW'(b_clip);
                     shown_in  = 1'b1;
                  end
               end
            end
            OP_HIDE: begin
               shown_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (csr_wdata != fw_ff) shown_in = 1'b0;
               fw_in = csr_wdata;
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_wdata != fh_ff) shown_in = 1'b0;
               fh_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= FRAME_WIDTH_RESET;
         fh_ff     <= FRAME_HEIGHT_RESET;
         shown_ff  <= 1'b0;
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
      end else begin
         fw_ff     <= fw_in;
         fh_ff     <= fh_in;
         shown_ff  <= shown_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   always_comb begin
      left_o   = OW'(left_ff);
      top_o    = OW'(top_ff);
      right_o  = OW'(right_ff);
      bottom_o = OW'(bottom_ff);
      win.shown  = shown_ff;
      win.hit    = shown_ff && x_c >= left_c && x_c <= right_c &&
                   y_c >= top_c && y_c <= bottom_c;
      win.left   = left_o[WIN_W-1:0];
      win.top    = top_o[WIN_W-1:0];
      win.right  = right_o[WIN_W-1:0];
      win.bottom = bottom_o[WIN_W-1:0];
   end

   assign row_off = RW'(y_c - top_c);
   assign col_off = RW'(x_c - left_c);

endmodule

// ----- design/and_xor_cursor_compositor.sv -----
// AND/XOR cursor compositor top level: one item in flight through the mask
// and background memories. An accepted beat is registered in stage 1 with the
// memory read, then its result in the output register; a new beat is taken once
// stage 1 empties, and a waiting result holds in the output register.
// Synchronous active-high reset: hidden cursor, zero window, frame 640x480,
// mask rows read zero; background memory holds no defined value.
`timescale 1ns / 1ps
module and_xor_cursor_compositor
   import axcc_pkg::*;
#(
   parameter int CURSOR_DIM    = 32,
   parameter int FRAME_DIM_MAX = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_op,
   input  logic [4:0]             req_mask_row,
   input  logic [31:0]            req_screen_mask_word,
   input  logic [31:0]            req_xor_mask_word,
   input  logic [15:0]            req_pos_x,
   input  logic [15:0]            req_pos_y,
   input  logic [PIXEL_W-1:0]     req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   output logic                   rsp_in_window,
   output logic                   rsp_cursor_visible,
   output logic [WIN_W-1:0]       rsp_win_left,
   output logic [WIN_W-1:0]       rsp_win_top,
   output logic [WIN_W-1:0]       rsp_win_right,
   output logic [WIN_W-1:0]       rsp_win_bottom,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FRAME_REG_W-1:0] csr_wdata
);

   localparam int RW = (CURSOR_DIM > 1) ? $clog2(CURSOR_DIM) : 1;
   localparam int AW = $clog2(CURSOR_DIM * CURSOR_DIM);

   op_type        op;
   logic          req_accept;
   win_info_type  win;
   logic [RW-1:0] row_off, col_off;

   logic          mask_we;
   logic [31:0]   and_word, xor_word, and_sh, xor_sh;
   logic          bg_we, bg_re;
   logic [AW-1:0] bg_addr;
   logic [PIXEL_W-1:0] bg_word;

   logic               s1_valid_ff, s1_valid_in;
   op_type             s1_op_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_inside_ff;
   logic [RW-1:0]      s1_col_ff;

   logic               done;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] pixel_in, rsp_pixel_ff;
   logic               rsp_in_window_ff, rsp_visible_ff;
   logic [WIN_W-1:0]   rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;

   assign op         = op_type'(req_op);
   assign req_stall  = s1_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   axcc_window #(
      .CURSOR_DIM    (CURSOR_DIM),
      .FRAME_DIM_MAX (FRAME_DIM_MAX),
      .RW            (RW)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .op          (op),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .csr_we      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .win         (win),
      .row_off     (row_off),
      .col_off     (col_off)
   );

   assign mask_we = req_accept && op == OP_LOAD && int'(req_mask_row) < CURSOR_DIM;

   axcc_mask_mem #(
      .DEPTH (CURSOR_DIM),
      .AW    (RW)
   ) u_mask_mem (
      .clock     (clock),
      .reset     (reset),
      .we        (mask_we),
      .waddr     (RW'(req_mask_row)),
      .wdata_and (req_screen_mask_word),
      .wdata_xor (req_xor_mask_word),
      .re        (req_accept),
      .raddr     (row_off),
      .rdata_and (and_word),
      .rdata_xor (xor_word)
   );

   assign bg_addr = AW'(AW'(row_off) * AW'(CURSOR_DIM)) + AW'(col_off);
   assign bg_we   = req_accept && op == OP_COMPOSE && win.hit;
   assign bg_re   = req_accept && op == OP_RESTORE && win.hit;

   axcc_bg_mem #(
      .DEPTH (CURSOR_DIM * CURSOR_DIM),
      .AW    (AW)
   ) u_bg_mem (
      .clock (clock),
      .we    (bg_we),
      .waddr (bg_addr),
      .wdata (req_pixel_in),
      .re    (bg_re),
      .raddr (bg_addr),
      .rdata (bg_word)
   );

   assign done        = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_valid_in = req_accept ? 1'b1 : (done ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = done ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= op;
         s1_pixel_ff  <= req_pixel_in;
         s1_inside_ff <= win.hit;
         s1_col_ff    <= col_off;
      end
   end

   // columns past the 32-bit mask word shift out to zero
   assign and_sh = and_word << s1_col_ff;
   assign xor_sh = xor_word << s1_col_ff;

   always_comb begin
      pixel_in = s1_pixel_ff;
      case (s1_op_ff)
         OP_COMPOSE: begin
            if (s1_inside_ff) begin
               pixel_in = (s1_pixel_ff & {PIXEL_W{and_sh[31]}}) ^ {PIXEL_W{xor_sh[31]}};
            end
         end
         OP_RESTORE: begin
            if (s1_inside_ff) begin
               pixel_in = bg_word;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_pixel_ff     <= pixel_in;
         rsp_in_window_ff <= s1_inside_ff &&
                             (s1_op_ff == OP_COMPOSE || s1_op_ff == OP_RESTORE);
         rsp_visible_ff   <= win.shown;
         rsp_left_ff      <= win.left;
         rsp_top_ff       <= win.top;
         rsp_right_ff     <= win.right;
         rsp_bottom_ff    <= win.bottom;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_out      = rsp_pixel_ff;
   assign rsp_in_window      = rsp_in_window_ff;
   assign rsp_cursor_visible = rsp_visible_ff;
   assign rsp_win_left       = rsp_left_ff;
   assign rsp_win_top        = rsp_top_ff;
   assign rsp_win_right      = rsp_right_ff;
   assign rsp_win_bottom     = rsp_bottom_ff;

endmodule

// ----- design/axcc_checker.sv -----
// Port-level checks of the cursor compositor, bound to the top level.
// Depends on axcc_pkg and and_xor_cursor_compositor_macros.svh.
`timescale 1ns / 1ps
`include "and_xor_cursor_compositor_macros.svh"
module axcc_checker
   import axcc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PIXEL_W-1:0] rsp_pixel_out,
   input logic               rsp_in_window,
   input logic               rsp_cursor_visible,
   input logic [WIN_W-1:0]   rsp_win_left,
   input logic [WIN_W-1:0]   rsp_win_top,
   input logic [WIN_W-1:0]   rsp_win_right,
   input logic [WIN_W-1:0]   rsp_win_bottom
);

   `AXCC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_win_left))
   `AXCC_ASSERT(a_hit_visible, clock, reset, rsp_valid && rsp_in_window |-> rsp_cursor_visible)
   `AXCC_ASSERT(a_hit_ordered, clock, reset, rsp_valid && rsp_in_window |-> rsp_win_left <= rsp_win_right && rsp_win_top <= rsp_win_bottom)
   `AXCC_ASSERT(a_one_in_flight, clock, reset, req_valid && !req_stall |=> req_stall)
   `AXCC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind and_xor_cursor_compositor axcc_checker u_axcc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_pixel_out      (rsp_pixel_out),
   .rsp_in_window      (rsp_in_window),
   .rsp_cursor_visible (rsp_cursor_visible),
   .rsp_win_left       (rsp_win_left),
   .rsp_win_top        (rsp_win_top),
   .rsp_win_right      (rsp_win_right),
   .rsp_win_bottom     (rsp_win_bottom)
);

// ----- dv/tb.sv -----
// Self-checking bench for the AND/XOR cursor compositor: directed and random
// beats on the item channel, frame size writes on the CSR port, and a scoreboard.
// Depends on axcc_pkg and the and_xor_cursor_compositor top level only.
`timescale 1ns / 1ps
module tb;
   import axcc_pkg::*;

   localparam int CURSOR_SIZE = 32;
   localparam int FRAME_LIMIT = 4096;
   localparam int BG_DEPTH    = CURSOR_SIZE * CURSOR_SIZE;
   localparam int PHASE_ITEMS = 480;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic [4:0]         row;
      logic [31:0]        and_word;
      logic [31:0]        xor_word;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [PIXEL_W-1:0] pixel;
   } pixel_cmd_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               in_window;
      logic               visible;
      logic [WIN_W-1:0]   left;
      logic [WIN_W-1:0]   top;
      logic [WIN_W-1:0]   right;
      logic [WIN_W-1:0]   bottom;
   } pixel_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [2:0]             req_op = '0;
   logic [4:0]             req_mask_row = '0;
   logic [31:0]            req_screen_mask_word = '0;
   logic [31:0]            req_xor_mask_word = '0;
   logic [15:0]            req_pos_x = '0;
   logic [15:0]            req_pos_y = '0;
   logic [PIXEL_W-1:0]     req_pixel_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_in_window;
   logic                   rsp_cursor_visible;
   logic [WIN_W-1:0]       rsp_win_left;
   logic [WIN_W-1:0]       rsp_win_top;
   logic [WIN_W-1:0]       rsp_win_right;
   logic [WIN_W-1:0]       rsp_win_bottom;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [FRAME_REG_W-1:0] csr_wdata = '0;

   // predicted cursor state
   logic [31:0]            and_rows [CURSOR_SIZE];
   logic [31:0]            xor_rows [CURSOR_SIZE];
   logic [PIXEL_W-1:0]     saved_bg [BG_DEPTH];
   bit                     bg_written [BG_DEPTH];
   logic [FRAME_REG_W-1:0] frame_w = FRAME_WIDTH_RESET;
   logic [FRAME_REG_W-1:0] frame_h = FRAME_HEIGHT_RESET;
   int unsigned            org_x = 0;
   int unsigned            org_y = 0;
   int unsigned            win_l = 0;
   int unsigned            win_t = 0;
   int unsigned            win_r = 0;
   int unsigned            win_b = 0;
   bit                     cursor_on = 1'b0;

   pixel_result_type       expected_pixels [$];
   pixel_result_type       want;
   int                     mismatch_count = 0;
   int                     sender_idle_pct = 0;
   int                     receiver_stall_pct = 0;
   int                     stall_hold_cycles = 0;

   and_xor_cursor_compositor #(
      .CURSOR_DIM    (CURSOR_SIZE),
      .FRAME_DIM_MAX (FRAME_LIMIT)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_mask_row         (req_mask_row),
      .req_screen_mask_word (req_screen_mask_word),
      .req_xor_mask_word    (req_xor_mask_word),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pixel_in         (req_pixel_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pixel_out        (rsp_pixel_out),
      .rsp_in_window        (rsp_in_window),
      .rsp_cursor_visible   (rsp_cursor_visible),
      .rsp_win_left         (rsp_win_left),
      .rsp_win_top          (rsp_win_top),
      .rsp_win_right        (rsp_win_right),
      .rsp_win_bottom       (rsp_win_bottom),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < CURSOR_SIZE; i++) begin
         and_rows[i] = '0;
         xor_rows[i] = '0;
      end
      for (int i = 0; i < BG_DEPTH; i++) begin
         saved_bg[i]   = '0;
         bg_written[i] = 1'b0;
      end
   end

   function automatic int unsigned frame_span(logic [FRAME_REG_W-1:0] v);
      return (v > FRAME_LIMIT) ? FRAME_LIMIT : v;
   endfunction

   function automatic bit in_cursor_window(logic [15:0] x, logic [15:0] y);
      return cursor_on && x >= win_l && x <= win_r && y >= win_t && y <= win_b;
   endfunction

   function automatic int unsigned bg_index(logic [15:0] x, logic [15:0] y);
      return ((y - win_t) * CURSOR_SIZE + (x - win_l)) % BG_DEPTH;
   endfunction

   function automatic pixel_result_type overlay_predict(pixel_cmd_type c);
      pixel_result_type res;
      int unsigned   w;
      int unsigned   h;
      int unsigned   col;
      int unsigned   row;
      int unsigned   idx;
      logic [7:0]    and_spread;
      logic [7:0]    xor_spread;
      w = frame_span(frame_w);
      h = frame_span(frame_h);
      res.pixel = c.pixel;
      res.in_window = 1'b0;
      case (c.op)
         OP_LOAD: begin
            and_rows[c.row] = c.and_word;
            xor_rows[c.row] = c.xor_word;
         end
         OP_PLACE: begin
            if (w != 0 && h != 0) begin
               cursor_on = 1'b0;
               org_x = c.x;
               org_y = c.y;
               if (c.x < w && c.y < h) begin
                  win_l = c.x;
                  win_t = c.y;
                  win_r = (c.x + CURSOR_SIZE - 1 >= w) ? w - 1 : c.x + CURSOR_SIZE - 1;
                  win_b = (c.y + CURSOR_SIZE - 1 >= h) ? h - 1 : c.y + CURSOR_SIZE - 1;
                  cursor_on = 1'b1;
               end
            end
         end
         OP_COMPOSE, OP_RESTORE: begin
            if (in_cursor_window(c.x, c.y)) begin
               idx = bg_index(c.x, c.y);
               res.in_window = 1'b1;
               if (c.op == OP_COMPOSE) begin
                  col = c.x - org_x;
                  row = (c.y - org_y) % CURSOR_SIZE;
                  and_spread = (col < 32 && and_rows[row][31 - col]) ? 8'hff : 8'h00;
                  xor_spread = (col < 32 && xor_rows[row][31 - col]) ? 8'hff : 8'h00;
                  saved_bg[idx]   = c.pixel;
                  bg_written[idx] = 1'b1;
                  res.pixel = (c.pixel & and_spread) ^ xor_spread;
               end else begin
                  res.pixel = saved_bg[idx];
               end
            end
         end
         OP_HIDE: cursor_on = 1'b0;
         default: ;
      endcase
      res.visible = cursor_on;
      res.left    = win_l[WIN_W-1:0];
      res.top     = win_t[WIN_W-1:0];
      res.right   = win_r[WIN_W-1:0];
      res.bottom  = win_b[WIN_W-1:0];
      return res;
   endfunction

   function automatic pixel_cmd_type cmd_of(logic [2:0] op, logic [15:0] x, logic [15:0] y,
                                            logic [PIXEL_W-1:0] pixel);
      pixel_cmd_type c;
      c.op       = op;
      c.row      = 5'($urandom);
      c.and_word = $urandom;
      c.xor_word = $urandom;
      c.x        = x;
      c.y        = y;
      c.pixel    = pixel;
      return c;
   endfunction

   function automatic pixel_cmd_type load_cmd(logic [4:0] row, logic [31:0] and_word,
                                              logic [31:0] xor_word);
      pixel_cmd_type c;
      c = cmd_of(OP_LOAD, 16'($urandom), 16'($urandom), 8'($urandom));
      c.row      = row;
      c.and_word = and_word;
      c.xor_word = xor_word;
      return c;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_pixel_cmd(pixel_cmd_type cmd);
      int               gap;
      pixel_result_type res;
      gap = 0;
      // never read a background byte that no compose has written
      if (cmd.op == OP_RESTORE && in_cursor_window(cmd.x, cmd.y) &&
          !bg_written[bg_index(cmd.x, cmd.y)])
         cmd.op = OP_COMPOSE;
      while (gap < 64 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op               <= cmd.op;
      req_mask_row         <= cmd.row;
      req_screen_mask_word <= cmd.and_word;
      req_xor_mask_word    <= cmd.xor_word;
      req_pos_x            <= cmd.x;
      req_pos_y            <= cmd.y;
      req_pixel_in         <= cmd.pixel;
      req_valid            <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = overlay_predict(cmd);
      expected_pixels.push_back(res);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_frame_reg(logic [CSR_INDEX_W-1:0] idx, logic [FRAME_REG_W-1:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) begin
         if (val != frame_w) cursor_on = 1'b0;
         frame_w = val;
      end else if (idx == CSR_FRAME_HEIGHT) begin
         if (val != frame_h) cursor_on = 1'b0;
         frame_h = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic pick_pixel_pos(output logic [15:0] x, output logic [15:0] y);
      int cx;
      int cy;
      if (cursor_on && $urandom_range(19) != 0) begin
         cx = int'(win_l) + int'($urandom_range(39)) - 4;
         cy = int'(win_t) + int'($urandom_range(39)) - 4;
      end else if ($urandom_range(9) == 0) begin
         cx = $urandom_range(65535);
         cy = $urandom_range(65535);
      end else begin
         cx = $urandom_range(frame_span(frame_w) + 4);
         cy = $urandom_range(frame_span(frame_h) + 4);
      end
      if (cx < 0) cx = 0;
      if (cy < 0) cy = 0;
      x = cx[15:0];
      y = cy[15:0];
   endtask

   task automatic test_directed();
      send_pixel_cmd(load_cmd(5'd0, 32'hffff_ffff, 32'h0000_0000));
      send_pixel_cmd(load_cmd(5'd31, 32'h0000_0000, 32'hffff_ffff));
      send_pixel_cmd(load_cmd(5'd1, 32'haaaa_aaaa, 32'h5555_5555));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd0, 16'd0, 8'ha5));
      send_pixel_cmd(cmd_of(OP_RESTORE, 16'd0, 16'd0, 8'h5a));
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd0, 16'd0, 8'h00));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd0, 16'd0, 8'hff));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd31, 16'd31, 8'h3c));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd1, 16'd1, 8'h81));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd32, 16'd0, 8'h77));
      send_pixel_cmd(cmd_of(OP_RESTORE, 16'd0, 16'd0, 8'h00));
      send_pixel_cmd(cmd_of(OP_RESTORE, 16'd31, 16'd31, 8'hff));
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd639, 16'd479, 8'h00));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd639, 16'd479, 8'h00));
      send_pixel_cmd(cmd_of(OP_RESTORE, 16'd639, 16'd479, 8'hff));
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd640, 16'd0, 8'h00));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd639, 16'd479, 8'hc3));
      send_pixel_cmd(cmd_of(OP_PLACE, 16'hffff, 16'hffff, 8'hff));
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd10, 16'd10, 8'h00));
      send_pixel_cmd(cmd_of(OP_HIDE, 16'd10, 16'd10, 8'h11));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd10, 16'd10, 8'h99));
      for (logic [3:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_pixel_cmd(cmd_of(op[2:0], 16'($urandom), 16'($urandom), 8'($urandom)));
   endtask

   task automatic test_frame_config();
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd5, 16'd5, 8'h00));
      write_frame_reg(CSR_FRAME_WIDTH, frame_w);
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd5, 16'd5, 8'h42));
      write_frame_reg(CSR_FRAME_WIDTH, 13'd0);
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd3, 16'd3, 8'h00));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd5, 16'd5, 8'h24));
      write_frame_reg(CSR_FRAME_WIDTH, 13'h1fff);
      write_frame_reg(CSR_FRAME_HEIGHT, 13'd4096);
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd4090, 16'd4090, 8'h00));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd4095, 16'd4095, 8'he7));
      send_pixel_cmd(cmd_of(OP_RESTORE, 16'd4095, 16'd4095, 8'h00));
      write_frame_reg(CSR_FRAME_HEIGHT, 13'd1);
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd0, 16'd0, 8'h00));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd31, 16'd0, 8'h18));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd0, 16'd1, 8'h18));
      write_frame_reg(CSR_SPARE_FIRST, 13'($urandom));
      write_frame_reg(CSR_SPARE_LAST, 13'($urandom));
      send_pixel_cmd(cmd_of(OP_COMPOSE, 16'd0, 16'd0, 8'h66));
      write_frame_reg(CSR_FRAME_HEIGHT, 13'd0);
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd0, 16'd0, 8'h00));
      write_frame_reg(CSR_FRAME_WIDTH, FRAME_WIDTH_RESET);
      write_frame_reg(CSR_FRAME_HEIGHT, FRAME_HEIGHT_RESET);
   endtask

   task automatic test_backpressure();
      logic [15:0] x;
      logic [15:0] y;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd100, 16'd100, 8'h00));
      @(posedge clock);
      stall_hold_cycles = 300;
      @(negedge clock);
      for (int i = 0; i < 64; i++) begin
         pick_pixel_pos(x, y);
         send_pixel_cmd(cmd_of(($urandom_range(1) != 0) ? OP_COMPOSE : OP_RESTORE,
                               x, y, 8'($urandom)));
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, logic [FRAME_REG_W-1:0] w,
                            logic [FRAME_REG_W-1:0] h);
      int          k;
      int          cx;
      logic [15:0] x;
      logic [15:0] y;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      write_frame_reg(CSR_FRAME_WIDTH, w);
      write_frame_reg(CSR_FRAME_HEIGHT, h);
      send_pixel_cmd(cmd_of(OP_PLACE, 16'd0, 16'd0, 8'h00));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         k = $urandom_range(99);
         if (k < 8) begin
            send_pixel_cmd(load_cmd(5'($urandom), $urandom, $urandom));
         end else if (k < 16) begin
            if ($urandom_range(9) == 0) begin
               x = 16'($urandom);
               y = 16'($urandom);
            end else begin
               cx = ($urandom_range(2) == 0) ?
                    int'(frame_span(frame_w)) - int'($urandom_range(40)) :
                    int'($urandom_range(frame_span(frame_w) + 2));
               x = (cx < 0) ? 16'd0 : cx[15:0];
               y = 16'($urandom_range(frame_span(frame_h) + 2));
            end
            send_pixel_cmd(cmd_of(OP_PLACE, x, y, 8'($urandom)));
         end else if (k < 18) begin
            send_pixel_cmd(cmd_of(OP_HIDE, 16'($urandom), 16'($urandom), 8'($urandom)));
         end else if (k < 20) begin
            send_pixel_cmd(cmd_of(OP_SPARE_FIRST + 3'($urandom_range(2)), 16'($urandom),
                                  16'($urandom), 8'($urandom)));
         end else begin
            pick_pixel_pos(x, y);
            send_pixel_cmd(cmd_of((k < 65) ? OP_COMPOSE : OP_RESTORE, x, y, 8'($urandom)));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_phase(0, 0, 13'd640, 13'd480);
      run_phase(84, 0, 13'd37, 13'd29);
      run_phase(0, 84, 13'h1fff, 13'd4097);
      run_phase(31, 31, 13'd4096, 13'd3);
   endtask

   always @(negedge clock) begin
      if (stall_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_cycles = stall_hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual pixel_out %0h",
                     $time, rsp_pixel_out);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_out", want.pixel, rsp_pixel_out);
            check_field("in_window", want.in_window, rsp_in_window);
            check_field("cursor_visible", want.visible, rsp_cursor_visible);
            check_field("win_left", want.left, rsp_win_left);
            check_field("win_top", want.top, rsp_win_top);
            check_field("win_right", want.right, rsp_win_right);
            check_field("win_bottom", want.bottom, rsp_win_bottom);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_frame_config();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- and_xor_cursor_compositor.f -----
+incdir+design
design/axcc_pkg.sv
design/axcc_mask_mem.sv
design/axcc_bg_mem.sv
design/axcc_window.sv
design/and_xor_cursor_compositor.sv
design/axcc_checker.sv
dv/tb.sv
